@@ design/pfe_pkg.sv @@
package pfe_pkg;

  localparam int WordW     = 32;
  localparam int FracBits  = 16;
  localparam int RawW      = 31;
  localparam int AbsW      = 33;
  localparam int LenW      = 34;
  localparam int MagW      = 62;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 31;
  localparam int CfgIdxW   = 3;

  localparam logic [MagW-1:0] MagCap = '1;
  localparam logic signed [WordW-1:0] GravityReset = -32'sd642908;
  localparam logic [RawW-1:0] UnitReset = 31'd65536;

  typedef enum logic [2:0] {
    KIND_GRAVITY,
    KIND_DRAG,
    KIND_SPRING,
    KIND_BUNGEE,
    KIND_BUOYANCY
  } kind_e;

  typedef enum logic [2:0] {
    MODE_ZERO,
    MODE_FIXY,
    MODE_DRAG,
    MODE_SPRING,
    MODE_BUNGEE,
    MODE_BUOY
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRAVITY_Y,
    REG_DRAG_LINEAR,
    REG_DRAG_QUADRATIC,
    REG_STIFFNESS,
    REG_REST_LENGTH,
    REG_MAX_DEPTH,
    REG_WATER_LEVEL,
    REG_BUOYANT_FORCE
  } reg_e;

  typedef struct packed {
    logic signed [WordW-1:0] gravity_y;
    logic [RawW-1:0]         drag_linear;
    logic [RawW-1:0]         drag_quadratic;
    logic [RawW-1:0]         stiffness;
    logic [RawW-1:0]         rest_length;
    logic [RawW-1:0]         max_depth;
    logic signed [WordW-1:0] water_level;
    logic [RawW-1:0]         buoyant_force;
  } cfg_t;

  typedef struct packed {
    mode_e                   mode;
    logic                    applied;
    logic [2:0]              pos;
    logic signed [WordW-1:0] fix_y;
  } ctrl_t;

  typedef struct packed {
    logic [2:0][AbsW-1:0] mag;
    logic [1:0]           shift;
  } vec_t;

endpackage

@@ design/particle_force_evaluator_unit.sv @@
// Throughput: one word per cycle unless stalled; every stage, including the 32-stage
// square root and the 31-stage divider, holds one word and advances when not stalled.
// The whole pipeline stalls only while the output register holds an untaken word.
// Reset clears all valid bits and loads the register defaults; data regs are not reset.
module particle_force_evaluator_unit import pfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [WordW-1:0]   pos_x_i,
  input  logic [WordW-1:0]   pos_y_i,
  input  logic [WordW-1:0]   pos_z_i,
  input  logic [WordW-1:0]   vel_x_i,
  input  logic [WordW-1:0]   vel_y_i,
  input  logic [WordW-1:0]   vel_z_i,
  input  logic [RawW-1:0]    mass_i,
  input  logic               finite_mass_i,
  input  logic [WordW-1:0]   other_x_i,
  input  logic [WordW-1:0]   other_y_i,
  input  logic [WordW-1:0]   other_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [WordW-1:0]   force_x_o,
  output logic [WordW-1:0]   force_y_o,
  output logic [WordW-1:0]   force_z_o,
  output logic               applied_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity_y      <= GravityReset;
      cfg_q.drag_linear    <= '0;
      cfg_q.drag_quadratic <= '0;
      cfg_q.stiffness      <= UnitReset;
      cfg_q.rest_length    <= UnitReset;
      cfg_q.max_depth      <= UnitReset;
      cfg_q.water_level    <= '0;
      cfg_q.buoyant_force  <= UnitReset;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_GRAVITY_Y:      cfg_q.gravity_y      <= cfg_wdata_i;
        REG_DRAG_LINEAR:    cfg_q.drag_linear    <= cfg_wdata_i[RawW-1:0];
        REG_DRAG_QUADRATIC: cfg_q.drag_quadratic <= cfg_wdata_i[RawW-1:0];
        REG_STIFFNESS:      cfg_q.stiffness      <= cfg_wdata_i[RawW-1:0];
        REG_REST_LENGTH:    cfg_q.rest_length    <= cfg_wdata_i[RawW-1:0];
        REG_MAX_DEPTH:      cfg_q.max_depth      <= cfg_wdata_i[RawW-1:0];
        REG_WATER_LEVEL:    cfg_q.water_level    <= cfg_wdata_i;
        REG_BUOYANT_FORCE:  cfg_q.buoyant_force  <= cfg_wdata_i[RawW-1:0];
        default:            cfg_q <= cfg_q;
      endcase
    end
  end

  logic out_valid_q;
  logic en;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  logic        fr_vld;
  logic [63:0] fr_sum;
  vec_t        fr_vec;
  ctrl_t       fr_ctrl;

  pfe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .vld_i         (in_valid_i),
    .cfg_i         (cfg_q),
    .req_type_i    (req_type_i),
    .pos_i         ({pos_z_i, pos_y_i, pos_x_i}),
    .vel_i         ({vel_z_i, vel_y_i, vel_x_i}),
    .mass_i        (mass_i),
    .finite_mass_i (finite_mass_i),
    .other_i       ({other_z_i, other_y_i, other_x_i}),
    .vld_o         (fr_vld),
    .sum_o         (fr_sum),
    .vec_o         (fr_vec),
    .ctrl_o        (fr_ctrl)
  );

  logic        sq_vld;
  logic [31:0] sq_root;
  vec_t        sq_vec;
  ctrl_t       sq_ctrl;

  pfe_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fr_vld),
    .sum_i  (fr_sum),
    .vec_i  (fr_vec),
    .ctrl_i (fr_ctrl),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .vec_o  (sq_vec),
    .ctrl_o (sq_ctrl)
  );

  logic            mg_vld;
  logic [MagW-1:0] mg_force;
  logic [LenW-1:0] mg_div;
  vec_t            mg_vec;
  ctrl_t           mg_ctrl;

  pfe_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (sq_vld),
    .cfg_i   (cfg_q),
    .root_i  (sq_root),
    .vec_i   (sq_vec),
    .ctrl_i  (sq_ctrl),
    .vld_o   (mg_vld),
    .force_o (mg_force),
    .div_o   (mg_div),
    .vec_o   (mg_vec),
    .ctrl_o  (mg_ctrl)
  );

  logic                     dv_vld;
  logic [2:0][DivSteps-1:0] dv_quo;
  logic [2:0]               dv_sat;
  ctrl_t                    dv_ctrl;

  pfe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (mg_vld),
    .force_i (mg_force),
    .div_i   (mg_div),
    .vec_i   (mg_vec),
    .ctrl_i  (mg_ctrl),
    .vld_o   (dv_vld),
    .quo_o   (dv_quo),
    .sat_o   (dv_sat),
    .ctrl_o  (dv_ctrl)
  );

  // Signed, saturated output words.
  logic [2:0][WordW-1:0] lane;
  logic [2:0][WordW-1:0] f_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_ctrl.pos[i]) begin
        lane[i] = dv_sat[i] ? 32'h7FFF_FFFF : {1'b0, dv_quo[i]};
      end else begin
        lane[i] = dv_sat[i] ? 32'h8000_0000 : (32'd0 - {1'b0, dv_quo[i]});
      end
    end
    f_d = '0;
    case (dv_ctrl.mode)
      MODE_FIXY:                          f_d[1] = dv_ctrl.fix_y;
      MODE_DRAG, MODE_SPRING, MODE_BUNGEE: f_d = lane;
      MODE_BUOY:                          f_d[1] = {1'b0, dv_quo[1]};
      default:                            f_d = '0;
    endcase
  end

  logic [2:0][WordW-1:0] force_q;
  logic                  applied_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      force_q   <= f_d;
      applied_q <= dv_ctrl.applied;
    end
  end

  assign out_valid_o = out_valid_q;
  assign force_x_o   = force_q[0];
  assign force_y_o   = force_q[1];
  assign force_z_o   = force_q[2];
  assign applied_o   = applied_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !applied_q) |->
      (force_q[0] == '0 && force_q[1] == '0 && force_q[2] == '0))
    else $error("force on a word that applies none");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled word lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !dv_vld) |=> !out_valid_q)
    else $error("taken word repeated");

endmodule

@@ design/pfe_front.sv @@
module pfe_front import pfe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  cfg_t                    cfg_i,
  input  logic [2:0]              req_type_i,
  input  logic [2:0][WordW-1:0]   pos_i,
  input  logic [2:0][WordW-1:0]   vel_i,
  input  logic [RawW-1:0]         mass_i,
  input  logic                    finite_mass_i,
  input  logic [2:0][WordW-1:0]   other_i,
  output logic                    vld_o,
  output logic [63:0]             sum_o,
  output vec_t                    vec_o,
  output ctrl_t                   ctrl_o
);

  logic [3:0] vld_q;

  // Input word register.
  logic [2:0]            kind_q;
  logic [2:0][WordW-1:0] pos_q, vel_q, other_q;
  logic [RawW-1:0]       mass_q;
  logic                  fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q  <= req_type_i;
      pos_q   <= pos_i;
      vel_q   <= vel_i;
      other_q <= other_i;
      mass_q  <= mass_i;
      fin_q   <= finite_mass_i;
    end
  end

  // Difference vector, magnitudes, range shift and buoyancy band.
  logic signed [AbsW-1:0]  d [3];
  logic [2:0][AbsW-1:0]    a;
  logic [1:0]              s;
  logic [2:0][RawW-1:0]    b_d;
  logic signed [AbsW-1:0]  y_w, top_w, bot_w;
  logic [AbsW-1:0]         depth_w;
  logic                    above_w, full_w;
  logic signed [63:0]      gp_d;
  ctrl_t                   c1_d;
  vec_t                    v1_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (kind_q == KIND_DRAG) begin
        d[i] = {vel_q[i][WordW-1], vel_q[i]};
      end else begin
        d[i] = $signed({pos_q[i][WordW-1], pos_q[i]}) -
               $signed({other_q[i][WordW-1], other_q[i]});
      end
      a[i] = d[i][AbsW-1] ? (~d[i] + 1'b1) : d[i];
    end
    if (a[0][32] | a[1][32] | a[2][32]) begin
      s = 2'd2;
    end else if (a[0][31] | a[1][31] | a[2][31]) begin
      s = 2'd1;
    end else begin
      s = 2'd0;
    end
    for (int i = 0; i < 3; i++) begin
      b_d[i] = RawW'(a[i] >> s);
    end

    y_w     = {pos_q[1][WordW-1], pos_q[1]};
    top_w   = $signed({cfg_i.water_level[WordW-1], cfg_i.water_level}) +
              $signed({2'b00, cfg_i.max_depth});
    bot_w   = $signed({cfg_i.water_level[WordW-1], cfg_i.water_level}) -
              $signed({2'b00, cfg_i.max_depth});
    above_w = y_w >= top_w;
    full_w  = (y_w <= bot_w) || (cfg_i.max_depth == '0);
    depth_w = top_w - y_w;

    gp_d = cfg_i.gravity_y * $signed({1'b0, mass_q});

    v1_d.mag   = a;
    v1_d.shift = s;
    c1_d.pos   = {d[2][AbsW-1], d[1][AbsW-1], d[0][AbsW-1]};
    c1_d.fix_y = {1'b0, cfg_i.buoyant_force};
    c1_d.mode    = MODE_ZERO;
    c1_d.applied = 1'b0;
    case (kind_q)
      KIND_GRAVITY: begin
        if (fin_q) begin
          c1_d.mode    = MODE_FIXY;
          c1_d.applied = 1'b1;
        end
      end
      KIND_DRAG: begin
        c1_d.mode    = MODE_DRAG;
        c1_d.applied = 1'b1;
      end
      KIND_SPRING: begin
        c1_d.mode    = MODE_SPRING;
        c1_d.applied = 1'b1;
      end
      KIND_BUNGEE: begin
        c1_d.mode = MODE_BUNGEE;
      end
      KIND_BUOYANCY: begin
        if (!above_w) begin
          c1_d.applied = 1'b1;
          if (full_w) begin
            c1_d.mode = MODE_FIXY;
          end else begin
            c1_d.mode   = MODE_BUOY;
            c1_d.pos[1] = 1'b1;
            v1_d.mag[1] = depth_w;
          end
        end
      end
      default: begin
        c1_d.mode = MODE_ZERO;
      end
    endcase
  end

  logic [2:0][RawW-1:0] b_q;
  logic signed [63:0]   gp_q;
  logic                 grav_q;
  ctrl_t                c1_q, c2_q, c3_q;
  vec_t                 v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q    <= b_d;
      gp_q   <= gp_d;
      grav_q <= kind_q == KIND_GRAVITY;
      c1_q   <= c1_d;
      v1_q   <= v1_d;
    end
  end

  // Squares and saturated gravity.
  logic [2:0][61:0] sq_q;
  logic [63:0]      gmag;
  logic [47:0]      gm;
  ctrl_t            c2_d;

  always_comb begin
    gmag = gp_q[63] ? (~gp_q + 1'b1) : gp_q;
    gm   = gmag[63:FracBits];
    c2_d = c1_q;
    if (grav_q) begin
      if (gp_q[63]) begin
        c2_d.fix_y = (gm >= 48'h8000_0000) ? 32'sh8000_0000 : WordW'(32'd0 - gm[31:0]);
      end else begin
        c2_d.fix_y = (gm >= 48'h8000_0000) ? 32'sh7FFF_FFFF : gm[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= b_q[i] * b_q[i];
      end
      c2_q <= c2_d;
      v2_q <= v1_q;
    end
  end

  logic [63:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
      c3_q  <= c2_q;
      v3_q  <= v2_q;
    end
  end

  assign vld_o  = vld_q[3];
  assign sum_o  = sum_q;
  assign vec_o  = v3_q;
  assign ctrl_o = c3_q;

endmodule

@@ design/pfe_sqrt.sv @@
module pfe_sqrt import pfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [63:0] sum_i,
  input  vec_t        vec_i,
  input  ctrl_t       ctrl_i,
  output logic        vld_o,
  output logic [31:0] root_o,
  output vec_t        vec_o,
  output ctrl_t       ctrl_o
);

  logic                 vld_q [SqrtSteps];
  logic [63:0]          x_q   [SqrtSteps];
  logic [63:0]          r_q   [SqrtSteps];
  vec_t                 vec_q [SqrtSteps];
  ctrl_t                ctrl_q[SqrtSteps];

  // One bit of the root per stage, from a bit pair of the radicand, most significant first.
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] x_in, r_in, trial;
    logic        v_in;
    vec_t        vec_in;
    ctrl_t       ctrl_in;

    if (k == 0) begin : g_first
      assign x_in    = sum_i;
      assign r_in    = '0;
      assign v_in    = vld_i;
      assign vec_in  = vec_i;
      assign ctrl_in = ctrl_i;
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign r_in    = r_q[k-1];
      assign v_in    = vld_q[k-1];
      assign vec_in  = vec_q[k-1];
      assign ctrl_in = ctrl_q[k-1];
    end

    assign trial = r_in + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (x_in >= trial) begin
          x_q[k] <= x_in - trial;
          r_q[k] <= (r_in >> 1) + Bit;
        end else begin
          x_q[k] <= x_in;
          r_q[k] <= r_in >> 1;
        end
        vec_q[k]  <= vec_in;
        ctrl_q[k] <= ctrl_in;
      end
    end
  end

  assign vld_o  = vld_q[SqrtSteps-1];
  assign root_o = r_q[SqrtSteps-1][31:0];
  assign vec_o  = vec_q[SqrtSteps-1];
  assign ctrl_o = ctrl_q[SqrtSteps-1];

endmodule

@@ design/pfe_mag.sv @@
module pfe_mag import pfe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  cfg_t            cfg_i,
  input  logic [31:0]     root_i,
  input  vec_t            vec_i,
  input  ctrl_t           ctrl_i,
  output logic            vld_o,
  output logic [MagW-1:0] force_o,
  output logic [LenW-1:0] div_o,
  output vec_t            vec_o,
  output ctrl_t           ctrl_o
);

  logic [3:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  // Length, stretch and the zero-length and slack cases.
  logic [LenW-1:0] len_d, diff_d, len0_q, diff0_q;
  logic [LenW-1:0] rest_w;
  ctrl_t           c0_d, c0_q, c1_q, c2_q, c3_q;
  vec_t            v0_q, v1_q, v2_q, v3_q;

  always_comb begin
    len_d  = LenW'(root_i) << vec_i.shift;
    rest_w = LenW'(cfg_i.rest_length);
    diff_d = (len_d >= rest_w) ? (len_d - rest_w) : (rest_w - len_d);
    c0_d   = ctrl_i;
    case (ctrl_i.mode)
      MODE_DRAG, MODE_SPRING: begin
        if (len_d == '0) begin
          c0_d.mode = MODE_ZERO;
        end
      end
      MODE_BUNGEE: begin
        if (len_d > rest_w) begin
          c0_d.applied = 1'b1;
        end else begin
          c0_d.mode = MODE_ZERO;
        end
      end
      default: begin
        c0_d.mode = ctrl_i.mode;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len0_q  <= len_d;
      diff0_q <= diff_d;
      c0_q    <= c0_d;
      v0_q    <= vec_i;
    end
  end

  logic [64:0]     p1_q, ps_q;
  logic [63:0]     sq_q;
  logic [LenW-1:0] len1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= cfg_i.drag_linear * len0_q;
      ps_q   <= cfg_i.stiffness * diff0_q;
      sq_q   <= len0_q[31:0] * len0_q[31:0];
      len1_q <= len0_q;
      c1_q   <= c0_q;
      v1_q   <= v0_q;
    end
  end

  // Quadratic drag term in two halves.
  logic [MagW-1:0] q1_q, qs_q;
  logic [54:0]     pa_q, pb_q;
  logic [LenW-1:0] len2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q   <= MagW'(p1_q >> FracBits);
      qs_q   <= MagW'(ps_q >> FracBits);
      pa_q   <= cfg_i.drag_quadratic * sq_q[39:16];
      pb_q   <= cfg_i.drag_quadratic * sq_q[63:40];
      len2_q <= len1_q;
      c2_q   <= c1_q;
      v2_q   <= v1_q;
    end
  end

  logic [79:0]     p2;
  logic [63:0]     q2w;
  logic [MagW-1:0] q2;
  logic [MagW:0]   dsum;
  logic [MagW-1:0] drag_mag, f_d;
  logic [LenW-1:0] div_d;

  always_comb begin
    p2       = {25'd0, pa_q} + {1'b0, pb_q, 24'd0};
    q2w      = p2[79:FracBits];
    q2       = (q2w > 64'(MagCap)) ? MagCap : q2w[MagW-1:0];
    dsum     = {1'b0, q1_q} + {1'b0, q2};
    drag_mag = dsum[MagW] ? MagCap : dsum[MagW-1:0];
    div_d    = len2_q;
    case (c2_q.mode)
      MODE_DRAG:                f_d = drag_mag;
      MODE_SPRING, MODE_BUNGEE: f_d = qs_q;
      MODE_BUOY: begin
        f_d   = MagW'(cfg_i.buoyant_force);
        div_d = {2'b00, cfg_i.max_depth, 1'b0};
      end
      default:                  f_d = '0;
    endcase
  end

  logic [MagW-1:0] f_q;
  logic [LenW-1:0] div_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q   <= f_d;
      div_q <= div_d;
      c3_q  <= c2_q;
      v3_q  <= v2_q;
    end
  end

  assign vld_o   = vld_q[3];
  assign force_o = f_q;
  assign div_o   = div_q;
  assign vec_o   = v3_q;
  assign ctrl_o  = c3_q;

endmodule

@@ design/pfe_div.sv @@
module pfe_div import pfe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic [MagW-1:0]          force_i,
  input  logic [LenW-1:0]          div_i,
  input  vec_t                     vec_i,
  input  ctrl_t                    ctrl_i,
  output logic                     vld_o,
  output logic [2:0][DivSteps-1:0] quo_o,
  output logic [2:0]               sat_o,
  output ctrl_t                    ctrl_o
);

  localparam int ProdW = MagW + AbsW;

  logic [2:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // Force times component magnitude, split into two partial products.
  logic [2:0][63:0] lo_q, hi_q;
  logic [LenW-1:0]  div0_q, div1_q, div2_q;
  ctrl_t            c0_q, c1_q, c2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= force_i[30:0] * vec_i.mag[i];
        hi_q[i] <= force_i[MagW-1:31] * vec_i.mag[i];
      end
      div0_q <= div_i;
      c0_q   <= ctrl_i;
    end
  end

  logic [2:0][ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= ProdW'(lo_q[i]) + {hi_q[i], 31'd0};
      end
      div1_q <= div0_q;
      c1_q   <= c0_q;
    end
  end

  // A quotient of 2^31 or more saturates the output word.
  logic [2:0][LenW-1:0]     rem0_q;
  logic [2:0][DivSteps-1:0] low0_q;
  logic [2:0]               sat0_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sat0_q[i] <= prod_q[i][ProdW-1:DivSteps] >= 64'(div1_q);
        rem0_q[i] <= prod_q[i][DivSteps+LenW-1:DivSteps];
        low0_q[i] <= prod_q[i][DivSteps-1:0];
      end
      div2_q <= div1_q;
      c2_q   <= c1_q;
    end
  end

  logic                     sv_q  [DivSteps];
  logic [2:0][LenW-1:0]     rem_q [DivSteps];
  logic [2:0][DivSteps-1:0] low_q [DivSteps];
  logic [2:0][DivSteps-1:0] quo_q [DivSteps];
  logic [2:0]               sat_q [DivSteps];
  logic [LenW-1:0]          dv_q  [DivSteps];
  ctrl_t                    cs_q  [DivSteps];

  // Restoring division, one quotient bit per stage.
  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    logic [2:0][LenW-1:0]     rem_in;
    logic [2:0][DivSteps-1:0] low_in, quo_in;
    logic [2:0]               sat_in;
    logic [LenW-1:0]          dv_in;
    ctrl_t                    c_in;
    logic                     v_in;
    logic [LenW:0]            t [3];

    if (j == 0) begin : g_first
      assign rem_in = rem0_q;
      assign low_in = low0_q;
      assign quo_in = '0;
      assign sat_in = sat0_q;
      assign dv_in  = div2_q;
      assign c_in   = c2_q;
      assign v_in   = vld_q[2];
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign low_in = low_q[j-1];
      assign quo_in = quo_q[j-1];
      assign sat_in = sat_q[j-1];
      assign dv_in  = dv_q[j-1];
      assign c_in   = cs_q[j-1];
      assign v_in   = sv_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j] <= 1'b0;
      end else if (en_i) begin
        sv_q[j] <= v_in;
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {rem_in[i], low_in[i][DivSteps-1]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if (t[i] >= {1'b0, dv_in}) begin
            rem_q[j][i] <= LenW'(t[i] - {1'b0, dv_in});
            quo_q[j][i] <= {quo_in[i][DivSteps-2:0], 1'b1};
          end else begin
            rem_q[j][i] <= LenW'(t[i]);
            quo_q[j][i] <= {quo_in[i][DivSteps-2:0], 1'b0};
          end
          low_q[j][i] <= {low_in[i][DivSteps-2:0], 1'b0};
        end
        sat_q[j] <= sat_in;
        dv_q[j]  <= dv_in;
        cs_q[j]  <= c_in;
      end
    end
  end

  assign vld_o  = sv_q[DivSteps-1];
  assign quo_o  = quo_q[DivSteps-1];
  assign sat_o  = sat_q[DivSteps-1];
  assign ctrl_o = cs_q[DivSteps-1];

  // The buoyancy lift is below the lift constant, so it never saturates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_o && ctrl_o.mode == MODE_BUOY) |-> !sat_o[1])
    else $error("buoyancy quotient saturated");

endmodule

@@ sim/particle_force_evaluator_unit_tb.sv @@
`timescale 1ns / 1ps

module particle_force_evaluator_unit_tb;
  import pfe_pkg::*;

  localparam longint unsigned ForceCap = (64'd1 << 62) - 64'd1;
  localparam int unsigned SettleCycles = 90;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] px, py, pz, vx, vy, vz;
    logic [30:0] mass;
    logic        fin;
    logic [31:0] ox, oy, oz;
  } particle_req_t;

  typedef struct {
    logic [31:0] fx, fy, fz;
    logic        applied;
  } force_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [WordW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         req_type_i = '0;
  logic [WordW-1:0]   pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [WordW-1:0]   vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [RawW-1:0]    mass_i = '0;
  logic               finite_mass_i = 1'b0;
  logic [WordW-1:0]   other_x_i = '0, other_y_i = '0, other_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [WordW-1:0]   force_x_o, force_y_o, force_z_o;
  logic               applied_o;

  particle_force_evaluator_unit dut (.*);

  always #5 clk_i = ~clk_i;

  cfg_t   cfg_m;
  force_t force_q[$];
  int     errors = 0;
  int     words_sent = 0;
  int     words_checked = 0;
  int     cfg_writes = 0;
  int     stall_mode = 0;  // 0 none, 1 random, 2 periodic
  bit     bursty = 1'b0;
  int     burst_left = 0;
  int     stall_phase = 0;

  // ---------------- force predictor ----------------

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> FracBits;
    return (p > ForceCap) ? ForceCap : p[63:0];
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    logic [64:0] r, t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (65'd1 << i);
      if (t * t <= {1'b0, x}) r = t;
    end
    return r[63:0];
  endfunction

  function automatic longint unsigned mag_of(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned vec_length(longint d[3]);
    longint unsigned mx, sum, a;
    int sh;
    mx = 0;
    sum = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) if (mag_of(d[i]) > mx) mx = mag_of(d[i]);
    while ((mx >> sh) >= 64'h8000_0000) sh++;
    for (int i = 0; i < 3; i++) begin
      a = mag_of(d[i]) >> sh;
      sum += a * a;
    end
    return floor_sqrt(sum) << sh;
  endfunction

  // Force of magnitude f pointing along -d.
  function automatic void push_along(longint unsigned f, longint d[3], longint unsigned len,
                                     ref force_t r);
    logic [127:0] q;
    longint unsigned m;
    longint v[3];
    for (int i = 0; i < 3; i++) begin
      q = ({64'd0, f} * {64'd0, mag_of(d[i])}) / {64'd0, len};
      m = (q > ForceCap) ? ForceCap : q[63:0];
      v[i] = sat32((d[i] < 0) ? longint'(m) : -longint'(m));
    end
    r.fx = v[0][31:0];
    r.fy = v[1][31:0];
    r.fz = v[2][31:0];
  endfunction

  function automatic force_t predict_force(particle_req_t w);
    force_t r;
    longint d[3];
    longint unsigned len, mag, diff, depth;
    longint p, y, top, bottom;
    logic [127:0] lift;
    r = '{32'd0, 32'd0, 32'd0, 1'b0};
    case (w.kind)
      KIND_GRAVITY: if (w.fin) begin
        p = longint'(cfg_m.gravity_y) * longint'({33'd0, w.mass});
        mag = mag_of(p) >> FracBits;
        r.fy = 32'(sat32((p < 0) ? -longint'(mag) : longint'(mag)));
        r.applied = 1'b1;
      end
      KIND_DRAG: begin
        d[0] = longint'($signed(w.vx));
        d[1] = longint'($signed(w.vy));
        d[2] = longint'($signed(w.vz));
        len = vec_length(d);
        r.applied = 1'b1;
        if (len != 0) begin
          mag = fx_mul(cfg_m.drag_linear, len) + fx_mul(cfg_m.drag_quadratic, fx_mul(len, len));
          if (mag > ForceCap) mag = ForceCap;
          push_along(mag, d, len, r);
        end
      end
      KIND_SPRING, KIND_BUNGEE: begin
        d[0] = longint'($signed(w.px)) - longint'($signed(w.ox));
        d[1] = longint'($signed(w.py)) - longint'($signed(w.oy));
        d[2] = longint'($signed(w.pz)) - longint'($signed(w.oz));
        len = vec_length(d);
        if (w.kind == KIND_SPRING) begin
          r.applied = 1'b1;
          if (len != 0) begin
            diff = (len >= cfg_m.rest_length) ? len - cfg_m.rest_length
                                              : cfg_m.rest_length - len;
            push_along(fx_mul(cfg_m.stiffness, diff), d, len, r);
          end
        end else if (len > cfg_m.rest_length) begin
          r.applied = 1'b1;
          push_along(fx_mul(cfg_m.stiffness, len - cfg_m.rest_length), d, len, r);
        end
      end
      KIND_BUOYANCY: begin
        y = longint'($signed(w.py));
        top = longint'(cfg_m.water_level) + longint'({33'd0, cfg_m.max_depth});
        bottom = longint'(cfg_m.water_level) - longint'({33'd0, cfg_m.max_depth});
        if (y < top) begin
          r.applied = 1'b1;
          if (y <= bottom || cfg_m.max_depth == 0) begin
            r.fy = {1'b0, cfg_m.buoyant_force};
          end else begin
            depth = top - y;
            lift = ({97'd0, cfg_m.buoyant_force} * {64'd0, depth})
                   / {96'd0, cfg_m.max_depth, 1'b0};
            r.fy = 32'(sat32(longint'(lift[63:0])));
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- driving ----------------

  task automatic cfg_write(reg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GRAVITY_Y:      cfg_m.gravity_y = val;
      REG_DRAG_LINEAR:    cfg_m.drag_linear = val[30:0];
      REG_DRAG_QUADRATIC: cfg_m.drag_quadratic = val[30:0];
      REG_STIFFNESS:      cfg_m.stiffness = val[30:0];
      REG_REST_LENGTH:    cfg_m.rest_length = val[30:0];
      REG_MAX_DEPTH:      cfg_m.max_depth = val[30:0];
      REG_WATER_LEVEL:    cfg_m.water_level = val;
      REG_BUOYANT_FORCE:  cfg_m.buoyant_force = val[30:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (force_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Drives one word, after an idle gap when a burst is used up, and returns at the edge that accepts it.
  task automatic send_word(particle_req_t w);
    if (bursty && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    req_type_i <= w.kind;
    pos_x_i <= w.px; pos_y_i <= w.py; pos_z_i <= w.pz;
    vel_x_i <= w.vx; vel_y_i <= w.vy; vel_z_i <= w.vz;
    mass_i <= w.mass;
    finite_mass_i <= w.fin;
    other_x_i <= w.ox; other_y_i <= w.oy; other_z_i <= w.oz;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    force_q = {force_q, predict_force(w)};
    words_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      1: out_stall_i <= ($urandom_range(0, 99) < 35);
      2: out_stall_i <= (stall_phase % 7) < 3;
      default: out_stall_i <= 1'b0;
    endcase
  end

  // ---------------- result checking ----------------

  always @(negedge clk_i) begin
    force_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (force_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected force word x=%h y=%h z=%h applied=%b", $time,
                 force_x_o, force_y_o, force_z_o, applied_o);
      end else begin
        e = force_q.pop_front();
        if (force_x_o !== e.fx) begin
          errors++;
          $display("%0t: force_x expected %h actual %h", $time, e.fx, force_x_o);
        end
        if (force_y_o !== e.fy) begin
          errors++;
          $display("%0t: force_y expected %h actual %h", $time, e.fy, force_y_o);
        end
        if (force_z_o !== e.fz) begin
          errors++;
          $display("%0t: force_z expected %h actual %h", $time, e.fz, force_z_o);
        end
        if (applied_o !== e.applied) begin
          errors++;
          $display("%0t: applied expected %b actual %b", $time, e.applied, applied_o);
        end
      end
    end
  end

  // ---------------- stimulus ----------------

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2, 3:    return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
    endcase
  endfunction

  function automatic particle_req_t rand_word();
    particle_req_t w;
    w.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    w.px = rand_coord(); w.py = rand_coord(); w.pz = rand_coord();
    w.vx = rand_coord(); w.vy = rand_coord(); w.vz = rand_coord();
    w.mass = $urandom_range(0, 1) ? 31'($urandom()) : 31'($urandom_range(0, 32'h0010_0000));
    w.fin = ($urandom_range(0, 4) != 0);
    // Anchors mostly sit close to the particle so spring lengths stay near rest.
    if ($urandom_range(0, 2) != 0) begin
      w.ox = w.px + 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
      w.oy = w.py + 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
      w.oz = w.pz + 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
    end else begin
      w.ox = rand_coord(); w.oy = rand_coord(); w.oz = rand_coord();
    end
    return w;
  endfunction

  function automatic particle_req_t mk(logic [2:0] k, logic [31:0] p, logic [31:0] v,
                                       logic [31:0] o, logic [30:0] m, logic f);
    particle_req_t w;
    w = '{k, p, p, p, v, v, v, m, f, o, o, o};
    return w;
  endfunction

  task automatic test_special_cases();
    particle_req_t w;
    send_word(mk(KIND_GRAVITY, 0, 0, 0, 31'h7fff_ffff, 1'b1));
    send_word(mk(KIND_GRAVITY, 0, 0, 0, 31'h0001_0000, 1'b0));   // infinite mass
    send_word(mk(KIND_DRAG, 0, 32'h0, 0, 0, 1'b1));              // zero velocity
    send_word(mk(KIND_DRAG, 0, 32'h8000_0000, 0, 0, 1'b1));
    send_word(mk(KIND_DRAG, 0, 32'h7fff_ffff, 0, 0, 1'b1));
    send_word(mk(KIND_SPRING, 32'h0003_0000, 0, 32'h0003_0000, 0, 1'b1));  // zero length
    send_word(mk(KIND_SPRING, 32'h7fff_ffff, 0, 32'h8000_0000, 0, 1'b1));  // widest span
    send_word(mk(KIND_SPRING, 32'h0000_8000, 0, 0, 0, 1'b1));
    send_word(mk(KIND_BUNGEE, 32'h0000_4000, 0, 0, 0, 1'b1));    // slack
    send_word(mk(KIND_BUNGEE, 32'h0002_0000, 0, 0, 0, 1'b1));
    send_word(mk(KIND_BUNGEE, 32'h8000_0000, 0, 32'h7fff_ffff, 0, 1'b1));
    send_word(mk(KIND_BUOYANCY, 32'h0001_0000, 0, 0, 0, 1'b1)); // at the top edge: out
    send_word(mk(KIND_BUOYANCY, 32'hffff_0000, 0, 0, 0, 1'b1)); // at the bottom: full
    send_word(mk(KIND_BUOYANCY, 32'h0000_8000, 0, 0, 0, 1'b1)); // partial band
    send_word(mk(KIND_BUOYANCY, 32'h8000_0000, 0, 0, 0, 1'b1));
    send_word(mk(KIND_BUOYANCY, 32'h7fff_ffff, 0, 0, 0, 1'b1));
    for (int k = 5; k <= 7; k++) send_word(mk(3'(k), 32'h1234_5678, 32'h0001_0000, 0, 1, 1'b1));
    w = mk(KIND_DRAG, 0, 0, 0, 0, 1'b1);
    w.vx = 32'h0003_0000; w.vy = 32'hfffc_0000; w.vz = 32'h0000_0001;
    send_word(w);
    drain();
  endtask

  task automatic test_register_extremes();
    logic [31:0] ext[4] = '{32'h0000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000};
    for (int e = 0; e < 4; e++) begin
      for (int r = 0; r < 8; r++) cfg_write(reg_e'(r), ext[(e + r) % 4]);
      send_word(mk(KIND_GRAVITY, 0, 0, 0, 31'h7fff_ffff, 1'b1));
      send_word(mk(KIND_DRAG, 0, 32'h0100_0000, 0, 0, 1'b1));
      send_word(mk(KIND_SPRING, 32'h0000_0100, 0, 0, 0, 1'b1));
      send_word(mk(KIND_BUNGEE, 32'h4000_0000, 0, 32'hc000_0000, 0, 1'b1));
      send_word(mk(KIND_BUOYANCY, 32'h0000_0000, 0, 0, 0, 1'b1));
      send_word(mk(KIND_BUOYANCY, 32'hffff_fff0, 0, 0, 0, 1'b1));
      drain();
    end
  endtask

  task automatic test_random_traffic(int count);
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(REG_GRAVITY_Y, 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000));
      cfg_write(REG_DRAG_LINEAR, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h4_0000));
      cfg_write(REG_DRAG_QUADRATIC, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h2000));
      cfg_write(REG_STIFFNESS, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h10_0000));
      cfg_write(REG_REST_LENGTH, $urandom_range(0, 32'h4_0000));
      cfg_write(REG_MAX_DEPTH, (ph == 5) ? 32'h0 : $urandom_range(1, 32'h0400_0000));
      cfg_write(REG_WATER_LEVEL, rand_coord());
      cfg_write(REG_BUOYANT_FORCE, $urandom());
      stall_mode = ph % 3;
      bursty = (ph % 2 == 1);
      burst_left = 0;
      for (int i = 0; i < count / 6; i++) send_word(rand_word());
      drain();
    end
    stall_mode = 0;
    bursty = 1'b0;
  endtask

  initial begin
    cfg_m = '{GravityReset, 31'd0, 31'd0, UnitReset, UnitReset, UnitReset, 32'sd0, UnitReset};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_register_extremes();
    test_random_traffic(1050);
    $display("Covered %0d request words, %0d force words checked, %0d register writes.",
             words_sent, words_checked, cfg_writes);
    $display("All five force kinds, unknown kinds and register extremes under stalls and gaps.");
    if (errors == 0 && force_q.size() == 0) begin
      $display("particle_force_evaluator_unit regression: pass");
    end else begin
      $display("particle_force_evaluator_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d force words outstanding.", force_q.size());
    $display("particle_force_evaluator_unit regression: fail");
    $finish;
  end

endmodule
